FILE: design/rmth_pkg.sv
// Shared types and constants for the two-heap running median block.
`timescale 1ns / 1ps
package rmth_pkg;

  // Heap selector: lower or upper heap.
  typedef enum logic {
    HEAP_LOWER = 1'b0,
    HEAP_UPPER = 1'b1
  } heap_sel_e;

  // Heap operation requested of the sift engine.
  typedef enum logic {
    OP_PUSH    = 1'b0,
    OP_REPLACE = 1'b1
  } heap_op_e;

endpackage

FILE: design/running_median_two_heaps.sv
// Top level of the two-heap running median.
// Usage:
//   Input channel sample_i / valid_i / stall_o carries one signed sample per
//   item. Output channel median_o, dropped_o / valid_o / stall_i returns one
//   result item per input item: the lower median of all accepted samples,
//   or dropped_o = 1 with the unchanged median once MAX_ITEMS are held.
//   Each heap lives in a single-port synchronous memory served by its own
//   sift engine. An item takes one push and, when the tops cross, a
//   replacement on both heaps in parallel. One item is in work at a time;
//   the next item is taken in the cycle after the result is delivered.
//   The result sits in an output register; while the receiver stalls it is
//   held and no new item is taken until it is delivered.
//   Reset clears both counts and all control state; heap memories are not
//   cleared since entries are read only below their count.
`timescale 1ns / 1ps
module running_median_two_heaps #(
  parameter int unsigned MAX_ITEMS    = 1024,
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    stall_o,
  input  logic [SAMPLE_WIDTH-1:0] sample_i,
  output logic                    valid_o,
  input  logic                    stall_i,
  output logic [SAMPLE_WIDTH-1:0] median_o,
  output logic                    dropped_o
);

  localparam int unsigned Depth = (MAX_ITEMS + 1) / 2;
  localparam int unsigned DW    = (Depth < 2) ? 2 : Depth;
  localparam int unsigned CW    = $clog2(DW) + 1;
  localparam int unsigned TW    = $clog2(MAX_ITEMS + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_PUSH, S_WPUSH, S_SWAP, S_WSWAP, S_OUT
  } state_e;

  state_e                        state_q;
  logic [CW-1:0]                 lcnt_q, ucnt_q;
  logic signed [SAMPLE_WIDTH-1:0] samp_q, med_q;
  logic                          drop_q;
  logic                          valid_q;
  logic                          lo_start, up_start, lo_busy, up_busy;
  rmth_pkg::heap_op_e            op;
  logic [CW-1:0]                 lo_cnt, up_cnt;
  logic signed [SAMPLE_WIDTH-1:0] lo_val, up_val, lo_top, up_top;
  logic                          accept, push_lo;
  logic [TW:0]                   total;

  assign total   = TW'(lcnt_q) + TW'(ucnt_q) + (TW+1)'(0);
  assign stall_o = (state_q != S_IDLE) || valid_q;
  assign accept  = valid_i && !stall_o;
  assign push_lo = (lcnt_q == ucnt_q);

  rmth_sift #(.Depth(DW), .Width(SAMPLE_WIDTH), .IsMax(1'b1)) u_lower (
    .clk_i, .rst_ni, .start_i(lo_start), .op_i(op), .cnt_i(lo_cnt),
    .val_i(lo_val), .busy_o(lo_busy), .top_o(lo_top)
  );
  rmth_sift #(.Depth(DW), .Width(SAMPLE_WIDTH), .IsMax(1'b0)) u_upper (
    .clk_i, .rst_ni, .start_i(up_start), .op_i(op), .cnt_i(up_cnt),
    .val_i(up_val), .busy_o(up_busy), .top_o(up_top)
  );

  // Launch requests to the sift engines.
  always_comb begin
    lo_start = 1'b0;
    up_start = 1'b0;
    op       = rmth_pkg::OP_PUSH;
    lo_cnt   = lcnt_q;
    up_cnt   = ucnt_q;
    lo_val   = samp_q;
    up_val   = samp_q;
    case (state_q)
      S_PUSH: begin
        lo_start = push_lo;
        up_start = !push_lo;
      end
      S_SWAP: begin
        op       = rmth_pkg::OP_REPLACE;
        lo_start = 1'b1;
        up_start = 1'b1;
        lo_val   = up_top;
        up_val   = lo_top;
      end
      default: ;
    endcase
  end

  // Sequence one item: push unless the store is full, optional top swap, then present the result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      lcnt_q  <= '0;
      ucnt_q  <= '0;
      samp_q  <= '0;
      med_q   <= '0;
      drop_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      if (valid_q && !stall_i) valid_q <= 1'b0;
      case (state_q)
        S_IDLE: if (accept) begin
          samp_q <= $signed(sample_i);
          if (total >= (TW+1)'(MAX_ITEMS)) begin
            drop_q  <= 1'b1;
            state_q <= S_OUT;
          end else begin
            drop_q  <= 1'b0;
            state_q <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (push_lo) lcnt_q <= lcnt_q + CW'(1);
          else         ucnt_q <= ucnt_q + CW'(1);
          state_q <= S_WPUSH;
        end
        S_WPUSH: if (!lo_busy && !up_busy) begin
          if (ucnt_q != '0 && up_top < lo_top) state_q <= S_SWAP;
          else                                  state_q <= S_OUT;
        end
        S_SWAP:  state_q <= S_WSWAP;
        S_WSWAP: if (!lo_busy && !up_busy) state_q <= S_OUT;
        S_OUT: begin
          med_q   <= (lcnt_q != '0) ? lo_top : '0;
          valid_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign valid_o   = valid_q;
  assign median_o  = med_q;
  assign dropped_o = drop_q;

endmodule

FILE: design/rmth_heap_mem.sv
// Synchronous single-port heap storage with registered read data.
`timescale 1ns / 1ps
module rmth_heap_mem #(
  parameter int unsigned Depth = 512,
  parameter int unsigned Width = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write the addressed entry, register its previous contents as read data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

FILE: design/rmth_sift.sv
// Sift engine: one heap push (sift up) or top replacement (sift down) on one memory.
`timescale 1ns / 1ps
module rmth_sift #(
  parameter int unsigned Depth = 512,
  parameter int unsigned Width = 16,
  parameter bit          IsMax = 1'b1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  rmth_pkg::heap_op_e       op_i,
  input  logic [$clog2(Depth):0]   cnt_i,
  input  logic signed [Width-1:0]  val_i,
  output logic                     busy_o,
  output logic signed [Width-1:0]  top_o
);

  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned CW = AW + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_UP_RD, S_UP_CMP, S_DN_RDL, S_DN_RDR, S_DN_CMP
  } state_e;

  state_e                 state_q;
  logic [CW-1:0]          idx_q, cnt_q;
  logic [CW-1:0]          par_w, lch_w, rch_w;
  logic signed [Width-1:0] val_q, lval_q, top_q;
  logic                   we;
  logic [AW-1:0]          addr;
  logic signed [Width-1:0] wdata, rdata;
  logic                   lbest, rbest;

  rmth_heap_mem #(.Depth(Depth), .Width(Width)) u_mem (
    .clk_i  (clk_i),
    .we_i   (we),
    .addr_i (addr),
    .wdata_i(wdata),
    .rdata_o(rdata)
  );

  // Ranks a above b for this heap's order.
  function automatic logic above(logic signed [Width-1:0] a, logic signed [Width-1:0] b);
    above = IsMax ? (a > b) : (a < b);
  endfunction

  assign par_w = (idx_q - CW'(1)) >> 1;
  assign lch_w = {idx_q[CW-2:0], 1'b1};
  assign rch_w = lch_w + CW'(1);

  assign lbest = (lch_w < cnt_q) && above(lval_q, val_q);
  assign rbest = (rch_w < cnt_q) && above(rdata, lbest ? lval_q : val_q);

  // Drive the memory port from the current step.
  always_comb begin
    we    = 1'b0;
    addr  = idx_q[AW-1:0];
    wdata = val_q;
    case (state_q)
      S_UP_RD:  addr = par_w[AW-1:0];
      S_UP_CMP: begin
        we = 1'b1;
        if (idx_q != '0 && above(val_q, rdata)) begin
          wdata = rdata;
        end
      end
      S_DN_RDL: addr = lch_w[AW-1:0];
      S_DN_RDR: addr = rch_w[AW-1:0];
      S_DN_CMP: begin
        we = 1'b1;
        if (rbest) begin
          wdata = rdata;
        end else if (lbest) begin
          wdata = lval_q;
        end
      end
      default: ;
    endcase
  end

  // Step through the sift, one level at a time.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      cnt_q   <= '0;
      val_q   <= '0;
      lval_q  <= '0;
      top_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: if (start_i) begin
          val_q <= val_i;
          cnt_q <= cnt_i;
          if (op_i == rmth_pkg::OP_PUSH) begin
            idx_q   <= cnt_i;
            state_q <= S_UP_RD;
            if (cnt_i == '0) top_q <= val_i;
          end else begin
            idx_q   <= '0;
            state_q <= S_DN_RDL;
          end
        end
        S_UP_RD: begin
          if (idx_q == '0) begin
            state_q <= S_UP_CMP;
          end else begin
            state_q <= S_UP_CMP;
          end
        end
        S_UP_CMP: begin
          if (idx_q != '0 && above(val_q, rdata)) begin
            idx_q   <= par_w;
            if (par_w == '0) top_q <= val_q;
            state_q <= S_UP_RD;
          end else begin
            if (idx_q == '0) top_q <= val_q;
            state_q <= S_IDLE;
          end
        end
        S_DN_RDL: state_q <= S_DN_RDR;
        S_DN_RDR: begin
          lval_q  <= rdata;
          state_q <= S_DN_CMP;
        end
        S_DN_CMP: begin
          if (idx_q == '0) begin
            top_q <= rbest ? rdata : (lbest ? lval_q : val_q);
          end
          if (rbest) begin
            idx_q   <= rch_w;
            state_q <= S_DN_RDL;
          end else if (lbest) begin
            idx_q   <= lch_w;
            state_q <= S_DN_RDL;
          end else begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign top_o  = top_q;

endmodule

FILE: dv/running_median_two_heaps_tb.sv
// Self-checking testbench for the two-heap running median block.
`timescale 1ns / 1ps
module running_median_two_heaps_tb;

  localparam int unsigned MaxItems    = 1024;
  localparam int unsigned SampleWidth = 16;
  localparam int unsigned HeapDepth   = (MaxItems + 1) / 2;
  localparam int unsigned NumRandom   = 1880;

  typedef logic signed [SampleWidth-1:0] sample_t;

  typedef struct packed {
    sample_t median;
    logic    dropped;
  } median_res_t;

  // Directed stimulus row: sample, whether the result is typed in, and its value.
  typedef struct packed {
    sample_t     sample;
    logic        fixed;
    median_res_t res;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        valid_i;
  logic        stall_o;
  sample_t     sample_i;
  logic        valid_o;
  logic        stall_i;
  logic [SampleWidth-1:0] median_o;
  logic        dropped_o;

  running_median_two_heaps #(
    .MAX_ITEMS   (MaxItems),
    .SAMPLE_WIDTH(SampleWidth)
  ) dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (valid_i),
    .stall_o  (stall_o),
    .sample_i (sample_i),
    .valid_o  (valid_o),
    .stall_i  (stall_i),
    .median_o (median_o),
    .dropped_o(dropped_o)
  );

  // Predictor state: lower half as max-heap, upper half as min-heap
  sample_t     low_heap [HeapDepth];
  sample_t     high_heap[HeapDepth];
  int unsigned low_cnt;
  int unsigned high_cnt;

  median_res_t pending_medians[$];
  int unsigned mismatch_cnt;
  int unsigned median_cnt;
  int unsigned drop_cnt;
  int unsigned sent_cnt;
  logic        tail_quiet;
  logic        hold_long;

  function automatic logic outranks(sample_t a, sample_t b, logic is_max);
    return is_max ? (a > b) : (a < b);
  endfunction

  function automatic void heap_insert(ref sample_t h[HeapDepth], ref int unsigned cnt,
                                      input sample_t v, input logic is_max);
    int unsigned i;
    int unsigned p;
    sample_t t;
    i = cnt;
    h[i] = v;
    cnt = i + 1;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (!outranks(h[i], h[p], is_max)) break;
      t = h[i]; h[i] = h[p]; h[p] = t;
      i = p;
    end
  endfunction

  function automatic void heap_swap_top(ref sample_t h[HeapDepth], input int unsigned cnt,
                                        input sample_t v, input logic is_max);
    int unsigned i;
    int unsigned l;
    int unsigned best;
    sample_t t;
    i = 0;
    h[0] = v;
    forever begin
      l = 2 * i + 1;
      best = i;
      if (l < cnt && outranks(h[l], h[best], is_max)) best = l;
      if (l + 1 < cnt && outranks(h[l + 1], h[best], is_max)) best = l + 1;
      if (best == i) break;
      t = h[i]; h[i] = h[best]; h[best] = t;
      i = best;
    end
  endfunction

  // Add one sample to the running set and return the new lower median
  function automatic median_res_t add_sample(sample_t s);
    median_res_t r;
    sample_t a;
    sample_t b;
    r.dropped = 1'b0;
    if (low_cnt + high_cnt >= MaxItems) begin
      r.dropped = 1'b1;
    end else begin
      if (low_cnt == high_cnt) heap_insert(low_heap, low_cnt, s, 1'b1);
      else heap_insert(high_heap, high_cnt, s, 1'b0);
      if (low_cnt > 0 && high_cnt > 0 && high_heap[0] < low_heap[0]) begin
        a = low_heap[0];
        b = high_heap[0];
        heap_swap_top(low_heap, low_cnt, b, 1'b1);
        heap_swap_top(high_heap, high_cnt, a, 1'b0);
      end
    end
    r.median = (low_cnt > 0) ? low_heap[0] : '0;
    return r;
  endfunction

  task automatic report_mismatch(string what, int exp_v, int got_v);
    mismatch_cnt++;
    $display("ERROR t=%0t result %0d: %s expected %0d got %0d",
             $time, median_cnt, what, exp_v, got_v);
  endtask

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop
  initial begin
    #20ms;
    $display("running_median_two_heaps: mismatch");
    $finish;
  end

  // Check each delivered result against the oldest expectation
  always @(posedge clk_i) begin
    median_res_t e;
    if (rst_ni && valid_o && !stall_i) begin
      if (pending_medians.size() == 0) begin
        report_mismatch("unexpected result, median", 0, $signed(median_o));
      end else begin
        e = pending_medians.pop_front();
        if (e.median !== median_o)
          report_mismatch("median", e.median, $signed(median_o));
        if (e.dropped !== dropped_o)
          report_mismatch("dropped", e.dropped, dropped_o);
      end
      median_cnt++;
      if (dropped_o === 1'b1) drop_cnt++;
    end
  end

  // Receiver: random stall bursts, one long hold-off, none at the tail
  initial begin
    int n;
    stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_long) begin
        stall_i <= 1'b1;
        repeat (400) @(negedge clk_i);
        hold_long = 1'b0;
        stall_i <= 1'b0;
      end else if (!tail_quiet && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 6);
        stall_i <= 1'b1;
        repeat (n) @(negedge clk_i);
        stall_i <= 1'b0;
      end
    end
  end

  // Offer one item and hold it until taken; valid stays high for a following item unless a random gap comes first
  task automatic send_sample(sample_t s, logic fixed, median_res_t res);
    median_res_t e;
    int n;
    if (!tail_quiet && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 6);
      valid_i <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
    valid_i  <= 1'b1;
    sample_i <= s;
    e = add_sample(s);
    if (fixed && e !== res) report_mismatch("directed row, median", res.median, e.median);
    pending_medians.push_back(e);
    sent_cnt++;
    do @(posedge clk_i); while (stall_o);
    @(negedge clk_i);
  endtask

  // Stimulus
  initial begin
    dir_row_t dir_rows[$];
    sample_t s;
    int unsigned k;
    int unsigned wait_cyc;
    valid_i = 1'b0;
    sample_i = '0;
    rst_ni = 1'b0;
    tail_quiet = 1'b0;
    hold_long = 1'b0;
    low_cnt = 0;
    high_cnt = 0;
    mismatch_cnt = 0;
    median_cnt = 0;
    drop_cnt = 0;
    sent_cnt = 0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: extremes, equal values, crossing tops
    dir_rows = '{
      '{16'sh8000, 1'b1, '{16'sh8000, 1'b0}},
      '{16'sh7fff, 1'b1, '{16'sh8000, 1'b0}},
      '{16'sh7fff, 1'b1, '{16'sh7fff, 1'b0}},
      '{16'sh8000, 1'b0, '0},
      '{16'sh0000, 1'b0, '0},
      '{16'sh0000, 1'b0, '0},
      '{16'sh0000, 1'b0, '0},
      '{16'shffff, 1'b0, '0},
      '{16'sh0001, 1'b0, '0},
      '{16'sh5555, 1'b0, '0},
      '{16'shaaaa, 1'b0, '0},
      '{16'sh0005, 1'b0, '0},
      '{16'sh0005, 1'b0, '0},
      '{16'sh0005, 1'b0, '0},
      '{16'sh7ffe, 1'b0, '0},
      '{16'sh8001, 1'b0, '0}
    };
    foreach (dir_rows[i]) send_sample(dir_rows[i].sample, dir_rows[i].fixed, dir_rows[i].res);

    // Random: mostly small spread to hit ties, some full range; fill past the store limit
    for (k = 0; k < NumRandom; k++) begin
      if (k == 300) hold_long = 1'b1;
      if (k == NumRandom - 150) tail_quiet = 1'b1;
      case ($urandom_range(0, 3))
        0: s = sample_t'($urandom_range(0, 65535));
        1: s = sample_t'($signed($urandom_range(0, 16)) - 8);
        2: s = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        default: s = sample_t'($signed($urandom_range(0, 2000)) - 1000);
      endcase
      send_sample(s, 1'b0, '0);
    end
    valid_i <= 1'b0;

    // Drain
    wait_cyc = 0;
    while (pending_medians.size() != 0 && wait_cyc < 100000) begin
      @(posedge clk_i);
      wait_cyc++;
    end
    repeat (60) @(posedge clk_i);
    $display("Sent %0d samples, checked %0d medians (%0d past a full store).",
             sent_cnt, median_cnt, drop_cnt);
    $display("Covered ties, extremes, crossing tops, long output stall and store full.");
    if (mismatch_cnt == 0 && pending_medians.size() == 0) begin
      $display("running_median_two_heaps: match");
    end else begin
      $display("running_median_two_heaps: mismatch");
    end
    $finish;
  end

endmodule
